### hdl/dpfa_pkg.sv
// ----------------------------------------------------------------------------
// dpfa_pkg
// Shared types and constants of the demand paging frame allocator.
// ----------------------------------------------------------------------------
package dpfa_pkg;

   localparam int PAGE_BYTES  = 4096;
   localparam int MAX_SLOTS   = 16;
   localparam int VIRT_PAGES  = 64;
   localparam int PHYS_FRAMES = 64;

   localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
   localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
   localparam int VPAGE_BITS = $clog2(VIRT_PAGES);
   localparam int FRAME_BITS = $clog2(PHYS_FRAMES);
   localparam int NP_BITS    = VPAGE_BITS + 1;
   localparam int CNT_BITS   = (VPAGE_BITS > FRAME_BITS) ? VPAGE_BITS : FRAME_BITS;
   localparam int SIZE_BITS  = 19;
   localparam int ADDR_BITS  = 18;
   localparam int MEM_DEPTH  = MAX_SLOTS * VIRT_PAGES;
   localparam int MEM_ABITS  = SLOT_BITS + VPAGE_BITS;

   localparam logic [1:0] CMD_CREATE    = 2'd0;
   localparam logic [1:0] CMD_TRANSLATE = 2'd1;
   localparam logic [1:0] CMD_EXIT      = 2'd2;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_NO_SPACE = 3'd2,
      ST_NO_SLOT  = 3'd3,
      ST_BAD_PID  = 3'd4,
      ST_OOB      = 3'd5,
      ST_NO_FRAME = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      RK_ERR, RK_CREATE, RK_HIT, RK_MAP, RK_EXIT
   } rsp_kind_type;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_CLEAR, S_LOOKUP, S_SEARCH, S_FREE_RD, S_FREE_WR
   } state_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [3:0]           pid;
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_BITS-1:0] size;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [3:0]           new_pid;
      logic [ADDR_BITS-1:0] phys_addr;
      logic                 faulted;
   } rsp_type;

   typedef struct packed {
      logic         load;
      logic         cnt_clr;
      logic         cnt_inc;
      logic         create_commit;
      logic         clear_wr;
      logic         lookup_rd;
      logic         map;
      logic         free_rd;
      logic         free_wr;
      logic         exit_commit;
      logic         rsp_fire;
      rsp_kind_type rsp_kind;
      status_type   rsp_code;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       bad_size;
      logic       no_space;
      logic       no_slot;
      logic       bad_pid;
      logic       oob;
      logic       np_zero;
      logic       present;
      logic       frame_free;
      logic       cnt_last;
      logic       free_last;
   } sts_type;

endpackage

### hdl/demand_paging_frame_allocator.sv
// ----------------------------------------------------------------------------
// demand_paging_frame_allocator
// Process slots, page reservation and first-fit frame mapping on demand.
// ----------------------------------------------------------------------------
// One command at a time: a beat is taken when start is high and busy is low,
// and exactly one result beat comes back with rsp_valid high for one cycle;
// the receiver cannot stall it, so it must take every result. A rejected
// command answers after its checks, a page hit after one page table read, a
// create after the new slot's 64 page table entries are cleared one a cycle,
// a page miss after the frame map is searched one frame a cycle, and an exit
// after a read then a write of each page table entry of the process. No
// clearing pass is needed after reset.
module demand_paging_frame_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dpfa_pkg::req_type req,
   output logic              rsp_valid,
   output dpfa_pkg::rsp_type rsp
);
   import dpfa_pkg::*;

   ctl_type ctl;
   sts_type sts;

   dpfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   dpfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result beat without a command in flight");

   a_fell_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("command finished without a result beat");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted command did not hold the block busy");

endmodule

### hdl/dpfa_ctrl.sv
// ----------------------------------------------------------------------------
// dpfa_ctrl
// Command sequencer: checks, clearing sweep, frame search and exit scan.
// ----------------------------------------------------------------------------
module dpfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dpfa_pkg::sts_type sts,
   output dpfa_pkg::ctl_type ctl
);
   import dpfa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.rsp_kind = RK_ERR;
      ctl.rsp_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (sts.cmd == CMD_CREATE) begin
               priority if (sts.bad_size) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_BAD_SIZE; state_in = S_IDLE;
               end else if (sts.no_space) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_NO_SPACE; state_in = S_IDLE;
               end else if (sts.no_slot) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_NO_SLOT; state_in = S_IDLE;
               end else begin
                  ctl.create_commit = 1'b1;
                  ctl.cnt_clr = 1'b1;
                  state_in = S_CLEAR;
               end
            end else if (sts.cmd == CMD_TRANSLATE) begin
               priority if (sts.bad_pid) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_BAD_PID; state_in = S_IDLE;
               end else if (sts.oob) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_OOB; state_in = S_IDLE;
               end else begin
                  ctl.lookup_rd = 1'b1;
                  state_in = S_LOOKUP;
               end
            end else if (sts.cmd == CMD_EXIT) begin
               priority if (sts.bad_pid) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_BAD_PID; state_in = S_IDLE;
               end else if (sts.np_zero) begin
                  ctl.exit_commit = 1'b1;
                  ctl.rsp_fire = 1'b1; ctl.rsp_kind = RK_EXIT; state_in = S_IDLE;
               end else begin
                  ctl.cnt_clr = 1'b1;
                  state_in = S_FREE_RD;
               end
            end else begin
               ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_BAD_PID; state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            ctl.clear_wr = 1'b1;
            ctl.cnt_inc  = 1'b1;
            if (sts.cnt_last) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_kind = RK_CREATE; state_in = S_IDLE;
            end
         end
         S_LOOKUP: begin
            if (sts.present) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_kind = RK_HIT; state_in = S_IDLE;
            end else begin
               ctl.cnt_clr = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (sts.frame_free) begin
               ctl.map = 1'b1;
               ctl.rsp_fire = 1'b1; ctl.rsp_kind = RK_MAP; state_in = S_IDLE;
            end else if (sts.cnt_last) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_code = ST_NO_FRAME; state_in = S_IDLE;
            end else begin
               ctl.cnt_inc = 1'b1;
            end
         end
         S_FREE_RD: begin
            ctl.free_rd = 1'b1;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            ctl.free_wr = 1'b1;
            if (sts.free_last) begin
               ctl.exit_commit = 1'b1;
               ctl.rsp_fire = 1'b1; ctl.rsp_kind = RK_EXIT; state_in = S_IDLE;
            end else begin
               ctl.cnt_inc = 1'b1;
               state_in = S_FREE_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hdl/dpfa_dp.sv
// ----------------------------------------------------------------------------
// dpfa_dp
// Datapath: slot table, frame map, page table memory and result register.
// ----------------------------------------------------------------------------
module dpfa_dp (
   input  logic              clock,
   input  logic              reset,
   input  dpfa_pkg::req_type req,
   input  dpfa_pkg::ctl_type ctl,
   output dpfa_pkg::sts_type sts,
   output logic              rsp_valid,
   output dpfa_pkg::rsp_type rsp
);
   import dpfa_pkg::*;

   req_type                 req_ff;
   logic [MAX_SLOTS-1:0]    running_ff;
   logic [SIZE_BITS-1:0]    bytes_ff [MAX_SLOTS];
   logic [PHYS_FRAMES-1:0]  used_ff;
   logic [NP_BITS-1:0]      resv_ff;
   logic [SLOT_BITS-1:0]    slot_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   // page table entry: present bit over frame number
   logic [FRAME_BITS:0]     mem [MEM_DEPTH];
   logic [FRAME_BITS:0]     rdata_ff;

   logic [SLOT_BITS-1:0]    pid;
   logic [VPAGE_BITS-1:0]   vpage;
   logic [SIZE_BITS-1:0]    pbytes;
   logic [NP_BITS-1:0]      np_create, np_exit, free_pages;
   logic [SIZE_BITS-1:0]    free_bytes;
   logic [SIZE_BITS:0]      size_rnd, bytes_rnd;
   logic [SLOT_BITS-1:0]    free_slot;
   logic                    any_free;
   logic [MEM_ABITS-1:0]    wr_addr, rd_addr;
   logic                    wr_en, rd_en;
   logic [FRAME_BITS:0]     wr_data;
   logic [FRAME_BITS-1:0]   frame;

   assign pid    = req_ff.pid[SLOT_BITS-1:0];
   assign vpage  = req_ff.addr[PAGE_BITS +: VPAGE_BITS];
   assign pbytes = bytes_ff[pid];
   assign frame  = cnt_ff[FRAME_BITS-1:0];

   assign size_rnd  = {1'b0, req_ff.size} + (SIZE_BITS+1)'(PAGE_BYTES - 1);
   assign bytes_rnd = {1'b0, pbytes} + (SIZE_BITS+1)'(PAGE_BYTES - 1);
   assign np_create = size_rnd[PAGE_BITS +: NP_BITS];
   assign np_exit   = bytes_rnd[PAGE_BITS +: NP_BITS];
   assign free_pages = (resv_ff >= NP_BITS'(PHYS_FRAMES)) ? '0 :
                       NP_BITS'(PHYS_FRAMES) - resv_ff;
   assign free_bytes = SIZE_BITS'({free_pages, {PAGE_BITS{1'b0}}});

   always_comb begin
      free_slot = '0;
      any_free  = 1'b0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (!running_ff[i]) begin
            free_slot = SLOT_BITS'(i);
            any_free  = 1'b1;
         end
      end
   end

   always_comb begin
      sts.cmd        = req_ff.cmd;
      sts.bad_size   = req_ff.size > SIZE_BITS'(VIRT_PAGES * PAGE_BYTES);
      sts.no_space   = req_ff.size > free_bytes;
      sts.no_slot    = !any_free;
      sts.bad_pid    = !running_ff[pid];
      sts.oob        = {1'b0, req_ff.addr} >= pbytes;
      sts.np_zero    = (np_exit == '0);
      sts.present    = rdata_ff[FRAME_BITS];
      sts.frame_free = !used_ff[frame];
      sts.cnt_last   = (cnt_ff == CNT_BITS'(VIRT_PAGES - 1));
      sts.free_last  = (NP_BITS'(cnt_ff) + NP_BITS'(1)) == np_exit;
   end

   // page table port selection
   always_comb begin
      wr_en   = ctl.clear_wr | ctl.map | (ctl.free_wr & rdata_ff[FRAME_BITS]);
      wr_addr = {pid, cnt_ff[VPAGE_BITS-1:0]};
      wr_data = '0;
      if (ctl.clear_wr) begin
         wr_addr = {slot_ff, cnt_ff[VPAGE_BITS-1:0]};
      end else if (ctl.map) begin
         wr_addr = {pid, vpage};
         wr_data = {1'b1, frame};
      end
      rd_en   = ctl.lookup_rd | ctl.free_rd;
      rd_addr = ctl.lookup_rd ? {pid, vpage} : {pid, cnt_ff[VPAGE_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = ctl.rsp_code;
      unique case (ctl.rsp_kind)
         RK_CREATE: rsp_in.new_pid = 4'(slot_ff);
         RK_HIT: begin
            rsp_in.phys_addr = ADDR_BITS'({rdata_ff[FRAME_BITS-1:0],
                                           req_ff.addr[PAGE_BITS-1:0]});
         end
         RK_MAP: begin
            rsp_in.phys_addr = ADDR_BITS'({frame, req_ff.addr[PAGE_BITS-1:0]});
            rsp_in.faulted   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req;
      end
      if (ctl.create_commit) begin
         slot_ff <= free_slot;
         bytes_ff[free_slot] <= req_ff.size;
      end
      if (ctl.exit_commit) begin
         bytes_ff[pid] <= '0;
      end
      if (ctl.rsp_fire) begin
         rsp_ff <= rsp_in;
      end
      if (ctl.cnt_clr) begin
         cnt_ff <= '0;
      end else if (ctl.cnt_inc) begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         used_ff      <= '0;
         resv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.rsp_fire;
         if (ctl.create_commit) begin
            running_ff[free_slot] <= 1'b1;
            resv_ff <= resv_ff + np_create;
         end
         if (ctl.exit_commit) begin
            running_ff[pid] <= 1'b0;
            resv_ff <= (resv_ff >= np_exit) ? resv_ff - np_exit : '0;
         end
         if (ctl.map) begin
            used_ff[frame] <= 1'b1;
         end
         if (ctl.free_wr && rdata_ff[FRAME_BITS]) begin
            used_ff[rdata_ff[FRAME_BITS-1:0]] <= 1'b0;
         end
      end
   end

   // byte counts are not reset; a slot's byte count reads as zero after exit
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### test/demand_paging_frame_allocator_test.sv
// ----------------------------------------------------------------------------
// demand_paging_frame_allocator_test
// Drives create, translate, exit and unknown commands with random gaps, predicts every
// result beat from a behavioural copy of the slot, page and frame tables and
// checks each result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module demand_paging_frame_allocator_test;
   import dpfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 200;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   demand_paging_frame_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // predicted allocator state
   logic          running_q [MAX_SLOTS];
   logic [18:0]   bytes_q   [MAX_SLOTS];
   logic          present_q [MEM_DEPTH];
   logic [5:0]    frame_of_q[MEM_DEPTH];
   logic          used_q    [PHYS_FRAMES];
   int            reserved_q;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      error_count;
   int      idle_cycles;
   bit      hold_off;
   int      gap_left;

   function automatic int pages_of(input int unsigned nbytes);
      return (nbytes + PAGE_BYTES - 1) / PAGE_BYTES;
   endfunction

   function automatic rsp_type predict_allocation(input req_type c);
      rsp_type r;
      int slot, fr, idx, np, vp;
      r = '0;
      r.status = ST_BAD_PID;
      case (c.cmd)
         CMD_CREATE: begin
            slot = -1;
            if (c.size > VIRT_PAGES * PAGE_BYTES) r.status = ST_BAD_SIZE;
            else if (c.size > ((reserved_q >= PHYS_FRAMES) ? 0 :
                     (PHYS_FRAMES - reserved_q) * PAGE_BYTES)) r.status = ST_NO_SPACE;
            else begin
               for (int i = MAX_SLOTS - 1; i >= 0; i--) if (!running_q[i]) slot = i;
               if (slot < 0) r.status = ST_NO_SLOT;
               else begin
                  running_q[slot] = 1'b1;
                  bytes_q[slot] = c.size;
                  for (int v = 0; v < VIRT_PAGES; v++) present_q[slot*VIRT_PAGES+v] = 1'b0;
                  reserved_q += pages_of(c.size);
                  r.status = ST_OK;
                  r.new_pid = slot[3:0];
               end
            end
         end
         CMD_TRANSLATE: begin
            if (running_q[c.pid]) begin
               if (c.addr >= bytes_q[c.pid]) r.status = ST_OOB;
               else begin
                  vp = c.addr / PAGE_BYTES;
                  idx = c.pid * VIRT_PAGES + vp;
                  r.status = ST_OK;
                  if (!present_q[idx]) begin
                     fr = -1;
                     for (int i = PHYS_FRAMES - 1; i >= 0; i--) if (!used_q[i]) fr = i;
                     if (fr < 0) r.status = ST_NO_FRAME;
                     else begin
                        used_q[fr] = 1'b1;
                        frame_of_q[idx] = fr[5:0];
                        present_q[idx] = 1'b1;
                        r.faulted = 1'b1;
                     end
                  end
                  if (r.status == ST_OK)
                     r.phys_addr = frame_of_q[idx] * PAGE_BYTES + c.addr % PAGE_BYTES;
               end
            end
         end
         CMD_EXIT: begin
            if (running_q[c.pid]) begin
               np = pages_of(bytes_q[c.pid]);
               for (int i = 0; i < np && i < VIRT_PAGES; i++) begin
                  idx = c.pid * VIRT_PAGES + i;
                  if (present_q[idx]) begin
                     used_q[frame_of_q[idx]] = 1'b0;
                     present_q[idx] = 1'b0;
                  end
               end
               reserved_q = (reserved_q >= np) ? reserved_q - np : 0;
               bytes_q[c.pid] = '0;
               running_q[c.pid] = 1'b0;
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int random_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // driver: one beat per accepted command, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req <= '0;
         gap_left = 0;
      end else if (start && !busy) begin
         start <= 1'b0;
         gap_left = random_gap();
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (pending_cmds.size() > 0 && !hold_off) begin
            req <= pending_cmds[0];
            expected_rsps.push_back(predict_allocation(pending_cmds.pop_front()));
            start <= 1'b1;
         end
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            idle_cycles <= 0;
            if (expected_rsps.size() == 0) report_mismatch("unexpected beat", 1, 0);
            else begin
               rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
               if (rsp.new_pid !== w.new_pid) report_mismatch("new_pid", rsp.new_pid, w.new_pid);
               if (rsp.phys_addr !== w.phys_addr)
                  report_mismatch("phys_addr", rsp.phys_addr, w.phys_addr);
               if (rsp.faulted !== w.faulted) report_mismatch("faulted", rsp.faulted, w.faulted);
            end
         end else if (start && !busy) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic req_type make_cmd(input logic [1:0] cmd, input int pid,
                                        input int addr, input int size);
      req_type c;
      c.cmd = cmd;
      c.pid = pid[3:0];
      c.addr = addr[17:0];
      c.size = size[18:0];
      return c;
   endfunction

   // mostly small processes, a few full-size ones
   function automatic int random_size();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return $urandom_range(0, 19'h7FFFF);
      if (k == 1) return VIRT_PAGES * PAGE_BYTES;
      if (k < 4) return $urandom_range(0, 20) * PAGE_BYTES;
      return $urandom_range(0, 6 * PAGE_BYTES);
   endfunction

   initial begin
      int pid;
      error_count = 0;
      idle_cycles = 0;
      hold_off = 1'b0;
      start = 1'b0;
      req = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         running_q[i] = 1'b0;
         bytes_q[i] = '0;
      end
      for (int i = 0; i < MEM_DEPTH; i++) begin
         present_q[i] = 1'b0;
         frame_of_q[i] = '0;
      end
      for (int i = 0; i < PHYS_FRAMES; i++) used_q[i] = 1'b0;
      reserved_q = 0;

      // directed: limits, unknown command, bad pids, full memory
      pending_cmds.push_back(make_cmd(2'd3, 15, 18'h3FFFF, 19'h7FFFF));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_EXIT, 15, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, VIRT_PAGES * PAGE_BYTES + 1));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, 19'h7FFFF));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, VIRT_PAGES * PAGE_BYTES));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, 1));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 1, 18'h3FFFF, 0));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 1, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 1, 5, 0));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 1, 18'h2AAAA, 0));
      pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 1, 18'h15555, 0));
      pending_cmds.push_back(make_cmd(CMD_EXIT, 1, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_EXIT, 1, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_EXIT, 0, 0, 0));
      // one full-size process, faulting in pages across its whole range
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, VIRT_PAGES * PAGE_BYTES));
      for (int i = 0; i < 18; i++)
         pending_cmds.push_back(make_cmd(CMD_TRANSLATE, 0, i * PAGE_BYTES * 4 % 18'h40000 +
                                (i / 16) * PAGE_BYTES + 18'hFFF, 0));
      pending_cmds.push_back(make_cmd(CMD_EXIT, 0, 0, 0));
      wait (pending_cmds.size() == 0 && !start);
      hold_off = 1'b1;
      wait (expected_rsps.size() == 0);
      hold_off = 1'b0;

      // fill the map and every slot
      for (int i = 0; i < MAX_SLOTS; i++)
         pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, 4 * PAGE_BYTES));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, 0));
      for (int i = 0; i < MAX_SLOTS; i++)
         for (int v = 0; v < 4; v++)
            pending_cmds.push_back(make_cmd(CMD_TRANSLATE, i, v * PAGE_BYTES + i, 0));
      pending_cmds.push_back(make_cmd(CMD_CREATE, 0, 0, 0));
      for (int i = 0; i < MAX_SLOTS; i++)
         pending_cmds.push_back(make_cmd(CMD_EXIT, i, 0, 0));

      // random part: mostly legal traffic on running slots
      for (int n = 0; n < 315; n++) begin
         int k;
         k = $urandom_range(0, 99);
         pid = $urandom_range(0, 3);
         if (k < 15)
            pending_cmds.push_back(make_cmd(CMD_CREATE, $urandom_range(0, 15), $urandom,
                                            random_size()));
         else if (k < 80)
            pending_cmds.push_back(make_cmd(CMD_TRANSLATE, ($urandom_range(0, 9) == 0) ?
               $urandom_range(0, 15) : pid,
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18'h3FFFF) :
               $urandom_range(0, 6 * PAGE_BYTES), 0));
         else if (k < 95)
            pending_cmds.push_back(make_cmd(CMD_EXIT, ($urandom_range(0, 4) == 0) ?
               $urandom_range(0, 15) : pid, $urandom, $urandom));
         else
            pending_cmds.push_back(make_cmd(2'd3, $urandom_range(0, 15), $urandom,
                                            $urandom));
      end

      wait (pending_cmds.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
